@@ src/sbpt_pkg.sv @@
// ----------------------------------------------------------------------------
// sbpt_pkg: shared buffer permission table package
// Field widths, request modes, error codes, grant bits and the table entry
// layout shared by the table storage and the top level.
// ----------------------------------------------------------------------------
package sbpt_pkg;

  // Field widths
  localparam int MODE_W     = 3;
  localparam int PID_W      = 16;
  localparam int ID_W       = 32;
  localparam int GRANT_W    = 2;
  localparam int SIZE_W     = 24;
  localparam int ERR_W      = 3;
  localparam int SLOT_IDX_W = 6;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SHARE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SIZE    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DESTROY = 3'd5;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_ARG  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_FULL     = 3'd2;
  localparam logic [ERR_W-1:0] ERR_DENIED   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG = 3'd4;

  // Grant bits
  localparam logic [GRANT_W-1:0] GRANT_NONE  = 2'b00;
  localparam logic [GRANT_W-1:0] GRANT_READ  = 2'b01;
  localparam logic [GRANT_W-1:0] GRANT_WRITE = 2'b10;
  localparam logic [GRANT_W-1:0] GRANT_RW    = 2'b11;

  // Id counter start / step
  localparam logic [ID_W-1:0] ID_FIRST = 32'd1;

  // Kernel pid
  localparam logic [PID_W-1:0] PID_KERNEL = 16'd0;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PID_W-1:0]   owner;
    logic [PID_W-1:0]   sharee;
    logic [GRANT_W-1:0] grant;
    logic [SIZE_W-1:0]  size;
  } entry_t;

  // Table update command
  typedef struct packed {
    logic wr_en;
    logic set_valid;
    logic clr_valid;
  } tbl_cmd_t;

endpackage

@@ src/sbpt_table.sv @@
// ----------------------------------------------------------------------------
// sbpt_table: descriptor storage
// Single-port descriptor memory with registered read and per-slot occupied
// bits; a free slot reads back as an all-zero entry.
// ----------------------------------------------------------------------------
module sbpt_table #(
  parameter int SLOTS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sbpt_pkg::tbl_cmd_t       cmd_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] addr_i,
  input  sbpt_pkg::entry_t         wr_entry_i,
  input  logic                     rd_en_i,
  output sbpt_pkg::entry_t         rd_entry_o,
  output logic                     rd_valid_o
);
  import sbpt_pkg::*;

  entry_t           mem [SLOTS];
  entry_t           rd_entry_q;
  logic             rd_valid_q;
  logic [SLOTS-1:0] valid_q;

  // Occupied bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.set_valid) begin
      valid_q[addr_i] <= 1'b1;
    end else if (cmd_i.clr_valid) begin
      valid_q[addr_i] <= 1'b0;
    end
  end

  // Descriptor memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_valid_q <= valid_q[addr_i];
    end
  end

  // Free slots read as an all-zero entry
  assign rd_entry_o = rd_valid_q ? rd_entry_q : '0;
  assign rd_valid_o = rd_valid_q;

endmodule

@@ src/shared_buffer_permission_table.sv @@
// ----------------------------------------------------------------------------
// shared_buffer_permission_table: transfer-buffer permission table
// Creates, shares, checks, sizes and destroys transfer descriptors held in a
// fixed table; reports the slot used so the buffer can be located.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+------------------------------
//  request | in        | in_valid_i / in_stall_o  | mode, caller_pid, xfer_id,
//          |           |                          | target_pid, permissions, length
//  result  | out       | out_valid_o / out_stall_i| ok, error_code, new_id,
//          |           |                          | buffer_size, slot_index
//
// A request that scans k slots (1..SLOTS) visits ST_FETCH and ST_TEST once per
// slot: a memory read and then a compare on the single table port. Requests
// rejected on their arguments alone go straight from ST_IDLE to ST_DONE.
// Reset clears all occupied bits at once and sets the id counter to one.
// in_stall_o is high while a request is in work; a stalled result holds the
// next request in its final state until the output register is free.
// ----------------------------------------------------------------------------
module shared_buffer_permission_table #(
  parameter int SLOTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sbpt_pkg::MODE_W-1:0]       mode_i,
  input  logic [sbpt_pkg::PID_W-1:0]        caller_pid_i,
  input  logic [sbpt_pkg::ID_W-1:0]         xfer_id_i,
  input  logic [sbpt_pkg::PID_W-1:0]        target_pid_i,
  input  logic [sbpt_pkg::GRANT_W-1:0]      permissions_i,
  input  logic [sbpt_pkg::SIZE_W-1:0]       length_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic [sbpt_pkg::ERR_W-1:0]        error_code_o,
  output logic [sbpt_pkg::ID_W-1:0]         new_id_o,
  output logic [sbpt_pkg::SIZE_W-1:0]       buffer_size_o,
  output logic [sbpt_pkg::SLOT_IDX_W-1:0]   slot_index_o
);
  import sbpt_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_TEST  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [IDX_W-1:0]      cnt_q, cnt_d;
  logic [ID_W-1:0]       next_id_q, next_id_d;

  // Latched request
  logic [MODE_W-1:0]     mode_q;
  logic [PID_W-1:0]      caller_q;
  logic [ID_W-1:0]       tid_q;
  logic [PID_W-1:0]      target_q;
  logic [GRANT_W-1:0]    perm_q;
  logic [SIZE_W-1:0]     len_q;

  // Pending result
  logic [ERR_W-1:0]      res_err_q, res_err_d;
  logic [ID_W-1:0]       res_nid_q, res_nid_d;
  logic [SIZE_W-1:0]     res_bsize_q, res_bsize_d;
  logic [SLOT_IDX_W-1:0] res_idx_q, res_idx_d;

  // Output register
  logic                  out_valid_q;
  logic                  out_ok_q;
  logic [ERR_W-1:0]      out_err_q;
  logic [ID_W-1:0]       out_nid_q;
  logic [SIZE_W-1:0]     out_bsize_q;
  logic [SLOT_IDX_W-1:0] out_idx_q;

  // Table interface
  tbl_cmd_t              tbl_cmd;
  entry_t                wr_entry;
  entry_t                rd_e;
  logic                  rd_valid;
  logic                  rd_en;

  // Compare unit results
  logic                  hit;
  logic                  is_owner;
  logic                  is_sharee;
  logic [GRANT_W-1:0]    need;
  logic                  acc;
  logic                  acc_any;
  logic [ID_W-1:0]       nid;
  logic                  in_accept;
  logic                  out_free;
  logic                  load_out;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign load_out  = (state_q == ST_DONE) && out_free;

  sbpt_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (tbl_cmd),
    .addr_i     (cnt_q),
    .wr_entry_i (wr_entry),
    .rd_en_i    (rd_en),
    .rd_entry_o (rd_e),
    .rd_valid_o (rd_valid)
  );

  // Access checks against the entry just read
  always_comb begin
    is_owner  = (caller_q == PID_KERNEL) || (rd_e.owner == caller_q);
    is_sharee = (rd_e.sharee == caller_q);
    unique case (mode_q)
      MODE_SHARE: need = GRANT_RW;
      MODE_WRITE: need = GRANT_WRITE;
      default:    need = GRANT_READ;
    endcase
    acc     = is_owner || (is_sharee && ((rd_e.grant & need) == need));
    acc_any = is_owner || (is_sharee && (rd_e.grant != GRANT_NONE));
    hit     = (mode_q == MODE_CREATE) ? !rd_valid
                                      : (rd_valid && (rd_e.id == tid_q));
    // counter skips zero on wrap
    nid     = (next_id_q == '0) ? ID_FIRST : next_id_q;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    next_id_d   = next_id_q;
    res_err_d   = res_err_q;
    res_nid_d   = res_nid_q;
    res_bsize_d = res_bsize_q;
    res_idx_d   = res_idx_q;
    tbl_cmd     = '0;
    wr_entry    = rd_e;
    rd_en       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d       = '0;
          res_err_d   = ERR_NONE;
          res_nid_d   = '0;
          res_bsize_d = '0;
          res_idx_d   = '0;
          // argument checks that need no table access
          priority if (mode_i == MODE_CREATE) begin
            if (length_i == '0) begin
              res_err_d = ERR_BAD_ARG;
              state_d   = ST_DONE;
            end else begin
              state_d   = ST_FETCH;
            end
          end else if (mode_i > MODE_DESTROY) begin
            res_err_d = ERR_BAD_ARG;
            state_d   = ST_DONE;
          end else if ((mode_i == MODE_SHARE) &&
                       ((target_pid_i == PID_KERNEL) || (permissions_i == GRANT_NONE))) begin
            res_err_d = ERR_BAD_ARG;
            state_d   = ST_DONE;
          end else if (xfer_id_i == '0) begin
            res_err_d = ERR_DENIED;
            state_d   = ST_DONE;
          end else begin
            state_d   = ST_FETCH;
          end
        end
      end

      ST_FETCH: begin
        rd_en   = 1'b1;
        state_d = ST_TEST;
      end

      ST_TEST: begin
        if (hit) begin
          state_d = ST_DONE;
          unique case (mode_q)
            MODE_CREATE: begin
              tbl_cmd.wr_en     = 1'b1;
              tbl_cmd.set_valid = 1'b1;
              wr_entry.id       = nid;
              wr_entry.owner    = target_q;
              wr_entry.sharee   = PID_KERNEL;
              wr_entry.grant    = GRANT_NONE;
              wr_entry.size     = len_q;
              next_id_d         = nid + ID_FIRST;
              res_nid_d         = nid;
              res_idx_d         = SLOT_IDX_W'(cnt_q);
            end
            MODE_SHARE: begin
              if (acc) begin
                tbl_cmd.wr_en   = 1'b1;
                wr_entry.sharee = target_q;
                wr_entry.grant  = perm_q;
                res_idx_d       = SLOT_IDX_W'(cnt_q);
              end else begin
                res_err_d = ERR_DENIED;
              end
            end
            MODE_READ, MODE_WRITE: begin
              priority if (!acc) begin
                res_err_d = ERR_DENIED;
              end else if (len_q > rd_e.size) begin
                res_err_d = ERR_TOO_LONG;
              end else begin
                res_idx_d = SLOT_IDX_W'(cnt_q);
              end
            end
            MODE_SIZE: begin
              if (acc_any) begin
                res_bsize_d = rd_e.size;
                res_idx_d   = SLOT_IDX_W'(cnt_q);
              end else begin
                res_err_d = ERR_DENIED;
              end
            end
            MODE_DESTROY: begin
              if (is_owner) begin
                tbl_cmd.clr_valid = 1'b1;
                res_idx_d         = SLOT_IDX_W'(cnt_q);
              end else begin
                res_err_d = ERR_DENIED;
              end
            end
            default: begin
              res_err_d = ERR_BAD_ARG;
            end
          endcase
        end else if (cnt_q == LAST_SLOT) begin
          state_d   = ST_DONE;
          res_err_d = (mode_q == MODE_CREATE) ? ERR_FULL : ERR_DENIED;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_FETCH;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      next_id_q <= ID_FIRST;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      next_id_q <= next_id_d;
    end
  end

  // Request and pending result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q   <= mode_i;
      caller_q <= caller_pid_i;
      tid_q    <= xfer_id_i;
      target_q <= target_pid_i;
      perm_q   <= permissions_i;
      len_q    <= length_i;
    end
    res_err_q   <= res_err_d;
    res_nid_q   <= res_nid_d;
    res_bsize_q <= res_bsize_d;
    res_idx_q   <= res_idx_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_ok_q    <= (res_err_q == ERR_NONE);
      out_err_q   <= res_err_q;
      out_nid_q   <= res_nid_q;
      out_bsize_q <= res_bsize_q;
      out_idx_q   <= res_idx_q;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign error_code_o  = out_err_q;
  assign new_id_o      = out_nid_q;
  assign buffer_size_o = out_bsize_q;
  assign slot_index_o  = out_idx_q;

  // Assertions
  a_ok_matches_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ok_o == (error_code_o == ERR_NONE)))
    else $error("ok flag disagrees with error code");

  a_fail_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |->
      ((new_id_o == '0) && (buffer_size_o == '0) && (slot_index_o == '0)))
    else $error("failed result carries nonzero fields");

  a_write_in_test : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_cmd.wr_en || tbl_cmd.clr_valid) |-> (state_q == ST_TEST) && hit)
    else $error("table updated outside a matching compare");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> (cnt_q <= LAST_SLOT))
    else $error("scan index past last slot");

  a_create_id_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_cmd.set_valid) |-> (wr_entry.id != '0))
    else $error("created entry would read as free");

endmodule

@@ dv/shared_buffer_permission_table_checker.sv @@
// ----------------------------------------------------------------------------
// shared_buffer_permission_table_checker: result checker for the permission table
// Watches the request and result channels, keeps its own copy of the
// descriptor table, predicts the reply to every accepted request and compares
// each accepted reply field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module shared_buffer_permission_table_checker #(
  parameter int SLOTS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [sbpt_pkg::MODE_W-1:0]     mode_i,
  input  logic [sbpt_pkg::PID_W-1:0]      caller_pid_i,
  input  logic [sbpt_pkg::ID_W-1:0]       xfer_id_i,
  input  logic [sbpt_pkg::PID_W-1:0]      target_pid_i,
  input  logic [sbpt_pkg::GRANT_W-1:0]    permissions_i,
  input  logic [sbpt_pkg::SIZE_W-1:0]     length_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            ok_i,
  input  logic [sbpt_pkg::ERR_W-1:0]      error_code_i,
  input  logic [sbpt_pkg::ID_W-1:0]       new_id_i,
  input  logic [sbpt_pkg::SIZE_W-1:0]     buffer_size_i,
  input  logic [sbpt_pkg::SLOT_IDX_W-1:0] slot_index_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sbpt_pkg::*;

  typedef struct packed {
    logic                  ok;
    logic [ERR_W-1:0]      error_code;
    logic [ID_W-1:0]       new_id;
    logic [SIZE_W-1:0]     buffer_size;
    logic [SLOT_IDX_W-1:0] slot_index;
  } reply_t;

  // Shadow copy of the descriptor table
  logic [ID_W-1:0]    tbl_id     [SLOTS];
  logic [PID_W-1:0]   tbl_owner  [SLOTS];
  logic [PID_W-1:0]   tbl_sharee [SLOTS];
  logic [GRANT_W-1:0] tbl_grant  [SLOTS];
  logic [SIZE_W-1:0]  tbl_size   [SLOTS];
  logic [ID_W-1:0]    id_counter;

  reply_t      expected_replies[$];
  reply_t      want;
  int unsigned mismatches = 0;
  int unsigned outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  function automatic void clear_entry(int s);
    tbl_id[s]     = '0;
    tbl_owner[s]  = '0;
    tbl_sharee[s] = '0;
    tbl_grant[s]  = GRANT_NONE;
    tbl_size[s]   = '0;
  endfunction

  // Lowest entry holding the id; id zero never matches
  function automatic int find_slot(logic [ID_W-1:0] id);
    if (id == '0) return -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Kernel and owner always pass; a sharee needs every requested grant bit
  function automatic logic may_access(int s, logic [PID_W-1:0] pid,
                                      logic [GRANT_W-1:0] need);
    return pid == PID_KERNEL || tbl_owner[s] == pid ||
           (tbl_sharee[s] == pid && (tbl_grant[s] & need) == need);
  endfunction

  // Applies one request to the shadow table and returns the expected reply
  function automatic reply_t serve_request(logic [MODE_W-1:0] mode,
                                           logic [PID_W-1:0] caller,
                                           logic [ID_W-1:0] tid,
                                           logic [PID_W-1:0] target,
                                           logic [GRANT_W-1:0] perm,
                                           logic [SIZE_W-1:0] len);
    reply_t r;
    int     s;
    r = '0;
    r.error_code = ERR_NONE;
    case (mode)
      MODE_CREATE: begin
        s = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (tbl_id[i] == '0) s = i;
        end
        if (len == '0) begin
          r.error_code = ERR_BAD_ARG;
        end else if (s < 0) begin
          r.error_code = ERR_FULL;
        end else begin
          // counter skips zero on wrap
          r.new_id = id_counter;
          id_counter = id_counter + ID_FIRST;
          if (r.new_id == '0) begin
            r.new_id = id_counter;
            id_counter = id_counter + ID_FIRST;
          end
          tbl_id[s]     = r.new_id;
          tbl_owner[s]  = target;
          tbl_sharee[s] = '0;
          tbl_grant[s]  = GRANT_NONE;
          tbl_size[s]   = len;
          r.slot_index  = SLOT_IDX_W'(s);
        end
      end
      MODE_SHARE, MODE_READ, MODE_WRITE, MODE_SIZE, MODE_DESTROY: begin
        if (mode == MODE_SHARE && (target == PID_KERNEL || perm == GRANT_NONE)) begin
          r.error_code = ERR_BAD_ARG;
        end else begin
          s = find_slot(tid);
          if (s < 0) begin
            r.error_code = ERR_DENIED;
          end else begin
            case (mode)
              MODE_SHARE: begin
                if (!may_access(s, caller, GRANT_RW)) begin
                  r.error_code = ERR_DENIED;
                end else begin
                  tbl_sharee[s] = target;
                  tbl_grant[s]  = perm;
                  r.slot_index  = SLOT_IDX_W'(s);
                end
              end
              MODE_READ, MODE_WRITE: begin
                if (!may_access(s, caller, (mode == MODE_READ) ? GRANT_READ : GRANT_WRITE)) begin
                  r.error_code = ERR_DENIED;
                end else if (len > tbl_size[s]) begin
                  r.error_code = ERR_TOO_LONG;
                end else begin
                  r.slot_index = SLOT_IDX_W'(s);
                end
              end
              MODE_SIZE: begin
                // either grant bit is enough to learn the size
                if (may_access(s, caller, GRANT_READ) || may_access(s, caller, GRANT_WRITE)) begin
                  r.buffer_size = tbl_size[s];
                  r.slot_index  = SLOT_IDX_W'(s);
                end else begin
                  r.error_code = ERR_DENIED;
                end
              end
              default: begin
                if (caller != PID_KERNEL && caller != tbl_owner[s]) begin
                  r.error_code = ERR_DENIED;
                end else begin
                  clear_entry(s);
                  r.slot_index = SLOT_IDX_W'(s);
                end
              end
            endcase
          end
        end
      end
      default: r.error_code = ERR_BAD_ARG;
    endcase
    r.ok = (r.error_code == ERR_NONE);
    return r;
  endfunction

  task automatic check_field(string name, logic [ID_W-1:0] exp_val, logic [ID_W-1:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) clear_entry(i);
      id_counter = ID_FIRST;
      expected_replies.delete();
      outstanding <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected transaction, expected none actual ok %0b error %0d",
                   $time, ok_i, error_code_i);
        end else begin
          want = expected_replies.pop_front();
          check_field("ok", ID_W'(want.ok), ID_W'(ok_i));
          check_field("error_code", ID_W'(want.error_code), ID_W'(error_code_i));
          check_field("new_id", want.new_id, new_id_i);
          check_field("buffer_size", ID_W'(want.buffer_size), ID_W'(buffer_size_i));
          check_field("slot_index", ID_W'(want.slot_index), ID_W'(slot_index_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_replies.push_back(serve_request(mode_i, caller_pid_i, xfer_id_i,
                                                 target_pid_i, permissions_i, length_i));
      end
      outstanding <= expected_replies.size();
    end
  end

endmodule

@@ dv/shared_buffer_permission_table_tb.sv @@
// ----------------------------------------------------------------------------
// shared_buffer_permission_table_tb: testbench top for the permission table
// Drives a directed sequence over every mode and corner of the table, then
// random requests in alternating fill and drain phases, with bursty input
// traffic and patterned output back-pressure. Checking is in the checker.
// ----------------------------------------------------------------------------
module shared_buffer_permission_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbpt_pkg::*;

  localparam int SLOT_COUNT   = 16;
  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;

  // Mode encodings the block does not define
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [MODE_W-1:0]     mode        = MODE_CREATE;
  logic [PID_W-1:0]      caller_pid  = '0;
  logic [ID_W-1:0]       xfer_id     = '0;
  logic [PID_W-1:0]      target_pid  = '0;
  logic [GRANT_W-1:0]    permissions = GRANT_NONE;
  logic [SIZE_W-1:0]     length      = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic                  ok;
  logic [ERR_W-1:0]      error_code;
  logic [ID_W-1:0]       new_id;
  logic [SIZE_W-1:0]     buffer_size;
  logic [SLOT_IDX_W-1:0] slot_index;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned creates_sent = 0;  // upper bound on ids handed out so far
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  bit          filling      = 1'b0;

  shared_buffer_permission_table #(.SLOTS(SLOT_COUNT)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .caller_pid_i  (caller_pid),
    .xfer_id_i     (xfer_id),
    .target_pid_i  (target_pid),
    .permissions_i (permissions),
    .length_i      (length),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .ok_o          (ok),
    .error_code_o  (error_code),
    .new_id_o      (new_id),
    .buffer_size_o (buffer_size),
    .slot_index_o  (slot_index)
  );

  shared_buffer_permission_table_checker #(.SLOTS(SLOT_COUNT)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .mode_i        (mode),
    .caller_pid_i  (caller_pid),
    .xfer_id_i     (xfer_id),
    .target_pid_i  (target_pid),
    .permissions_i (permissions),
    .length_i      (length),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .ok_i          (ok),
    .error_code_i  (error_code),
    .new_id_i      (new_id),
    .buffer_size_i (buffer_size),
    .slot_index_i  (slot_index),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one request, wait for acceptance, then maybe end the burst
  task automatic send_request(logic [MODE_W-1:0] m, logic [PID_W-1:0] caller,
                              logic [ID_W-1:0] tid, logic [PID_W-1:0] target,
                              logic [GRANT_W-1:0] perm, logic [SIZE_W-1:0] len);
    mode        <= m;
    caller_pid  <= caller;
    xfer_id     <= tid;
    target_pid  <= target;
    permissions <= perm;
    length      <= len;
    in_valid    <= 1'b1;
    if (m == MODE_CREATE) creates_sent++;
    items_sent++;
    do @(posedge clk_i); while (in_stall);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4))
        @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  // Mostly a small pool so owners and sharees collide, some kernel, some wide
  function automatic logic [PID_W-1:0] pick_pid();
    int unsigned      roll;
    logic [PID_W-1:0] pid;
    roll = $urandom_range(0, 19);
    if (roll < 3) pid = PID_KERNEL;
    else if (roll < 17) pid = PID_W'($urandom_range(1, 4));
    else pid = PID_W'($urandom);
    return pid;
  endfunction

  // Mostly recently issued ids, some older ones, zero and wild values
  function automatic logic [ID_W-1:0] pick_tid();
    int unsigned     roll, back;
    logic [ID_W-1:0] id;
    roll = $urandom_range(0, 19);
    if (roll < 2) begin
      id = '0;
    end else if (roll < 4) begin
      id = $urandom;
    end else if (roll < 7) begin
      id = $urandom_range(1, creates_sent);
    end else begin
      back = $urandom_range(0, 24);
      id = (back < creates_sent) ? creates_sent - back : ID_FIRST;
    end
    return id;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_length(bit for_create);
    int unsigned       roll;
    logic [SIZE_W-1:0] len;
    roll = $urandom_range(0, 9);
    if (roll == 0) len = '1;
    else if (roll == 1) len = SIZE_W'($urandom);
    else if (roll == 2) len = '0;
    else if (for_create) len = SIZE_W'($urandom_range(1, 64));
    else len = SIZE_W'($urandom_range(0, 80));
    return len;
  endfunction

  // Fill phases favor create, drain phases favor destroy
  task automatic send_random_request();
    int unsigned        roll, create_w, destroy_w;
    logic [MODE_W-1:0]  m;
    logic [PID_W-1:0]   caller;
    logic [GRANT_W-1:0] perm;
    create_w  = filling ? 40 : 6;
    destroy_w = filling ? 8 : 34;
    roll = $urandom_range(0, 99);
    if (roll < create_w) begin
      m = MODE_CREATE;
    end else if (roll < create_w + destroy_w) begin
      m = MODE_DESTROY;
    end else if (roll < create_w + destroy_w + 4) begin
      m = roll[0] ? MODE_UNUSED_LO : MODE_UNUSED_HI;
    end else begin
      case ($urandom_range(0, 3))
        0:       m = MODE_SHARE;
        1:       m = MODE_READ;
        2:       m = MODE_WRITE;
        default: m = MODE_SIZE;
      endcase
    end
    caller = (m == MODE_DESTROY && $urandom_range(0, 1) == 0) ? PID_KERNEL : pick_pid();
    perm = GRANT_W'($urandom_range(0, 3));
    send_request(m, caller, pick_tid(), pick_pid(), perm, pick_length(m == MODE_CREATE));
  endtask

  // Receiver back-pressure, with one long hold-off to fill the block
  initial begin : receiver
    int unsigned style, span;
    bit          held;
    held = 1'b0;
    @(posedge clk_i);
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(20, 200);
      if (!held && items_sent >= 400) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      for (int c = 0; c < span; c++) begin
        case (style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ($urandom_range(0, 4) != 0);
          default: out_stall <= c[0];
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 30);

    // lookup before anything exists, zero-length create, two creates at size extremes
    send_request(MODE_SIZE,    PID_KERNEL, 32'd1, '0, GRANT_NONE, '0);
    send_request(MODE_CREATE,  16'd3,      '0, 16'd7, GRANT_NONE, '0);
    send_request(MODE_CREATE,  16'd3,      '0, 16'd7, GRANT_NONE, '1);
    send_request(MODE_CREATE,  16'd3,      '0, 16'hFFFF, GRANT_RW, 24'd1);
    // share rules: read-only sharee, bad target, no bits, sharee cannot reshare
    send_request(MODE_SHARE,   16'd7,      32'd1, 16'd9, GRANT_READ, '0);
    send_request(MODE_SHARE,   16'd7,      32'd1, PID_KERNEL, GRANT_RW, '0);
    send_request(MODE_SHARE,   16'd7,      32'd1, 16'd9, GRANT_NONE, '0);
    send_request(MODE_SHARE,   16'd9,      32'd1, 16'd10, GRANT_RW, '0);
    // checks: length equal to size, missing grant, too long, kernel
    send_request(MODE_READ,    16'd9,      32'd1, '0, GRANT_NONE, '1);
    send_request(MODE_WRITE,   16'd9,      32'd1, '0, GRANT_NONE, 24'd1);
    send_request(MODE_READ,    16'hFFFF,   32'd2, '0, GRANT_NONE, 24'd2);
    send_request(MODE_WRITE,   PID_KERNEL, 32'd2, '0, GRANT_NONE, 24'd1);
    send_request(MODE_SIZE,    16'd9,      32'd1, '0, GRANT_NONE, '0);
    send_request(MODE_SIZE,    16'd3,      32'd2, '0, GRANT_NONE, '0);
    // a second share replaces the first sharee
    send_request(MODE_SHARE,   16'hFFFF,   32'd2, 16'd5, GRANT_WRITE, '0);
    send_request(MODE_SHARE,   PID_KERNEL, 32'd2, 16'd6, GRANT_RW, '0);
    send_request(MODE_WRITE,   16'd5,      32'd2, '0, GRANT_NONE, '0);
    send_request(MODE_WRITE,   16'd6,      32'd2, '0, GRANT_NONE, 24'd1);
    // destroy by sharee is refused, kernel succeeds, entry is gone afterward
    send_request(MODE_DESTROY, 16'd9,      32'd1, '0, GRANT_NONE, '0);
    send_request(MODE_DESTROY, PID_KERNEL, 32'd1, '0, GRANT_NONE, '0);
    send_request(MODE_READ,    PID_KERNEL, 32'd1, '0, GRANT_NONE, '0);
    send_request(MODE_UNUSED_LO, PID_KERNEL, 32'd2, 16'd1, GRANT_RW, 24'd1);
    send_request(MODE_UNUSED_HI, 16'hFFFF, '1, '1, GRANT_RW, '1);
    send_request(MODE_READ,    PID_KERNEL, '0, '0, GRANT_NONE, '0);
    // freed slot is reused; owner destroys its own entry
    send_request(MODE_CREATE,  16'd1,      '0, PID_KERNEL, GRANT_NONE, 24'd5);
    send_request(MODE_DESTROY, 16'hFFFF,   32'd2, '0, GRANT_NONE, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) filling = !filling;
      send_random_request();
    end

    in_valid <= 1'b0;
    // let the checker count the last accepted request
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
